/* hw/rtl/fpbcd_pkg.sv */
// shared types and constants of the float to packed bcd converter
`default_nettype none

package fpbcd_pkg;

  // width of the truncated integer part, 10^18 - 1 fits in 60 bits
  localparam int unsigned BinW      = 60;
  localparam int unsigned NumDigits = 18;
  localparam int unsigned BcdW      = 4 * NumDigits;

  localparam logic [15:0]     ExpEdge   = 16'd59;
  localparam logic [BinW-1:0] BcdLimit  = 60'd1000000000000000000;
  localparam logic [63:0]     IndefLow  = 64'hc000000000000000;
  localparam logic [7:0]      IndefByte = 8'hff;
  localparam logic [7:0]      NegByte   = 8'h80;
  localparam logic [7:0]      PosByte   = 8'h00;

  typedef enum logic [1:0] {
    KindNum,
    KindZero,
    KindIndef,
    KindDenorm
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  sign;
  } ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/fpbcd_front.sv */
// operand classification and alignment stage ahead of the digit chain
`default_nettype none

module fpbcd_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic                     sign_i,
  input  wire logic [15:0]              exponent_i,
  input  wire logic [63:0]              mantissa_i,
  input  wire logic                     is_zero_i,
  input  wire logic                     is_nan_i,
  input  wire logic                     is_inf_i,
  input  wire logic                     is_subnorm_i,
  output logic                          valid_o,
  output logic [fpbcd_pkg::BinW-1:0]    bin_o,
  output fpbcd_pkg::ctl_t               ctl_o
);

  logic                       valid_q;
  logic [fpbcd_pkg::BinW-1:0] bin_q, bin_d;
  fpbcd_pkg::ctl_t            ctl_q, ctl_d;
  logic [5:0]                 shamt;
  logic [63:0]                shifted;
  logic                       too_big;

  // only meaningful for exponents up to 59, where the amount is 4 or more
  assign shamt   = 6'd63 - exponent_i[5:0];
  assign shifted = mantissa_i >> shamt;
  assign too_big = (mantissa_i[63:4] >= fpbcd_pkg::BcdLimit);

  always_comb begin
    bin_d      = shifted[fpbcd_pkg::BinW-1:0];
    ctl_d.sign = sign_i;
    if (is_zero_i) begin
      ctl_d.kind = fpbcd_pkg::KindZero;
    end else if (is_nan_i || is_inf_i) begin
      ctl_d.kind = fpbcd_pkg::KindIndef;
    end else if (is_subnorm_i) begin
      ctl_d.kind = fpbcd_pkg::KindDenorm;
    end else if (exponent_i > fpbcd_pkg::ExpEdge) begin
      ctl_d.kind = fpbcd_pkg::KindIndef;
    end else if ((exponent_i == fpbcd_pkg::ExpEdge) && too_big) begin
      ctl_d.kind = fpbcd_pkg::KindIndef;
    end else begin
      ctl_d.kind = fpbcd_pkg::KindNum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bin_q <= bin_d;
      ctl_q <= ctl_d;
    end
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign ctl_o   = ctl_q;

endmodule

`default_nettype wire

/* hw/rtl/fpbcd_cell.sv */
// one double-dabble step: correct every digit, shift in the next binary bit
`default_nettype none

module fpbcd_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [fpbcd_pkg::BinW-1:0] bin_i,
  input  wire logic [fpbcd_pkg::BcdW-1:0] bcd_i,
  input  wire fpbcd_pkg::ctl_t          ctl_i,
  output logic                          valid_o,
  output logic [fpbcd_pkg::BinW-1:0]    bin_o,
  output logic [fpbcd_pkg::BcdW-1:0]    bcd_o,
  output fpbcd_pkg::ctl_t               ctl_o
);

  logic                       valid_q;
  logic [fpbcd_pkg::BinW-1:0] bin_q, bin_d;
  logic [fpbcd_pkg::BcdW-1:0] bcd_q, bcd_d;
  logic [fpbcd_pkg::BcdW-1:0] adj;
  fpbcd_pkg::ctl_t            ctl_q;

  always_comb begin
    adj = bcd_i;
    for (int d = 0; d < fpbcd_pkg::NumDigits; d++) begin
      if (bcd_i[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_i[4*d +: 4] + 4'd3;
      end
    end
    bcd_d = {adj[fpbcd_pkg::BcdW-2:0], bin_i[fpbcd_pkg::BinW-1]};
    bin_d = {bin_i[fpbcd_pkg::BinW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      ctl_q <= ctl_i;
    end
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;
  assign ctl_o   = ctl_q;

endmodule

`default_nettype wire

/* hw/rtl/float_to_packed_bcd_store_top.sv */
// top level of the extended-real to 18-digit packed bcd converter
// Converts one extended-real operand per cycle into its ten-byte packed BCD
// image, truncating any fraction. The transfer edge classifies and aligns the
// operand, then a chain of 60 double-dabble cells takes one binary bit each,
// then the output register formats the bytes. The chain holds up to 61 items
// in flight and moves as one; it halts only while a result sits unaccepted in
// the output register, so with out_ready_i high an item is taken every cycle.
`default_nettype none

module float_to_packed_bcd_store_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        sign_i,
  input  wire logic [15:0] exponent_i,
  input  wire logic [63:0] mantissa_i,
  input  wire logic        is_zero_i,
  input  wire logic        is_nan_i,
  input  wire logic        is_inf_i,
  input  wire logic        is_subnorm_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      low_bytes_o,
  output logic [7:0]       byte_eight_o,
  output logic [7:0]       sign_byte_o,
  output logic             invalid_o
);

  localparam int unsigned NumCells = fpbcd_pkg::BinW;

  logic                       advance;
  logic                       valid_c [NumCells+1];
  logic [fpbcd_pkg::BinW-1:0] bin_c   [NumCells+1];
  logic [fpbcd_pkg::BcdW-1:0] bcd_c   [NumCells+1];
  fpbcd_pkg::ctl_t            ctl_c   [NumCells+1];

  logic        out_valid_q;
  logic [63:0] low_bytes_q, low_bytes_d;
  logic [7:0]  byte_eight_q, byte_eight_d;
  logic [7:0]  sign_byte_q, sign_byte_d;
  logic        invalid_q, invalid_d;

  // the whole chain moves unless a finished result is still waiting
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  fpbcd_front u_front (
    .clk_i,
    .rst_ni,
    .en_i          (advance),
    .valid_i       (in_valid_i),
    .sign_i,
    .exponent_i,
    .mantissa_i,
    .is_zero_i,
    .is_nan_i,
    .is_inf_i,
    .is_subnorm_i,
    .valid_o       (valid_c[0]),
    .bin_o         (bin_c[0]),
    .ctl_o         (ctl_c[0])
  );

  assign bcd_c[0] = '0;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    fpbcd_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (advance),
      .valid_i (valid_c[k]),
      .bin_i   (bin_c[k]),
      .bcd_i   (bcd_c[k]),
      .ctl_i   (ctl_c[k]),
      .valid_o (valid_c[k+1]),
      .bin_o   (bin_c[k+1]),
      .bcd_o   (bcd_c[k+1]),
      .ctl_o   (ctl_c[k+1])
    );
  end

  always_comb begin
    low_bytes_d  = '0;
    byte_eight_d = '0;
    sign_byte_d  = ctl_c[NumCells].sign ? fpbcd_pkg::NegByte : fpbcd_pkg::PosByte;
    invalid_d    = 1'b0;
    case (ctl_c[NumCells].kind)
      fpbcd_pkg::KindNum: begin
        low_bytes_d  = bcd_c[NumCells][63:0];
        byte_eight_d = bcd_c[NumCells][fpbcd_pkg::BcdW-1:64];
      end
      fpbcd_pkg::KindZero: begin
        low_bytes_d = '0;
      end
      fpbcd_pkg::KindDenorm: begin
        sign_byte_d = fpbcd_pkg::PosByte;
      end
      fpbcd_pkg::KindIndef: begin
        low_bytes_d  = fpbcd_pkg::IndefLow;
        byte_eight_d = fpbcd_pkg::IndefByte;
        sign_byte_d  = fpbcd_pkg::IndefByte;
        invalid_d    = 1'b1;
      end
      default: begin
        low_bytes_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_c[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      low_bytes_q  <= low_bytes_d;
      byte_eight_q <= byte_eight_d;
      sign_byte_q  <= sign_byte_d;
      invalid_q    <= invalid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign low_bytes_o  = low_bytes_q;
  assign byte_eight_o = byte_eight_q;
  assign sign_byte_o  = sign_byte_q;
  assign invalid_o    = invalid_q;

  // every binary bit has been shifted into the digits at the end of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_c[NumCells] |-> (bin_c[NumCells] == '0))
    else $error("binary bits left over at end of chain");

  // a finished item reaches the output register when the chain moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_c[NumCells] && advance) |=> out_valid_o)
    else $error("item lost between chain and output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |->
      (sign_byte_o == fpbcd_pkg::IndefByte) && (byte_eight_o == fpbcd_pkg::IndefByte)
      && (low_bytes_o == fpbcd_pkg::IndefLow))
    else $error("invalid raised without indefinite pattern");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !invalid_o) |->
      ((sign_byte_o == fpbcd_pkg::NegByte) || (sign_byte_o == fpbcd_pkg::PosByte))
      && (byte_eight_o[7:4] <= 4'd9) && (byte_eight_o[3:0] <= 4'd9))
    else $error("bad sign byte or top digits on a valid result");

endmodule

`default_nettype wire

/* dv/float_to_packed_bcd_store_top_test.sv */
// self-checking testbench for the float to packed bcd converter top level
module float_to_packed_bcd_store_top_test;

  typedef struct packed {
    logic        sign;
    logic [15:0] exponent;
    logic [63:0] mantissa;
    logic        is_zero;
    logic        is_nan;
    logic        is_inf;
    logic        is_subnorm;
  } operand_t;

  typedef struct packed {
    logic [63:0] low_bytes;
    logic [7:0]  byte_eight;
    logic [7:0]  sign_byte;
    logic        invalid;
  } bcd_image_t;

  typedef struct {
    operand_t   op;
    bit         typed;
    bcd_image_t img;
  } stim_row_t;

  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned DrainCycles = 70;
  localparam int unsigned ItemsPerPhase = 325;

  localparam bcd_image_t ZeroPos = '{64'd0, 8'd0, fpbcd_pkg::PosByte, 1'b0};
  localparam bcd_image_t ZeroNeg = '{64'd0, 8'd0, fpbcd_pkg::NegByte, 1'b0};
  localparam bcd_image_t Indef   = '{fpbcd_pkg::IndefLow, fpbcd_pkg::IndefByte,
                                     fpbcd_pkg::IndefByte, 1'b1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        sign_i = 1'b0;
  logic [15:0] exponent_i = '0;
  logic [63:0] mantissa_i = '0;
  logic        is_zero_i = 1'b0;
  logic        is_nan_i = 1'b0;
  logic        is_inf_i = 1'b0;
  logic        is_subnorm_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] low_bytes_o;
  logic [7:0]  byte_eight_o;
  logic [7:0]  sign_byte_o;
  logic        invalid_o;

  bcd_image_t  pending_images[$];
  stim_row_t   directed_rows[$];
  int unsigned n_mismatch = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  float_to_packed_bcd_store_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sign_i        (sign_i),
    .exponent_i    (exponent_i),
    .mantissa_i    (mantissa_i),
    .is_zero_i     (is_zero_i),
    .is_nan_i      (is_nan_i),
    .is_inf_i      (is_inf_i),
    .is_subnorm_i  (is_subnorm_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .low_bytes_o   (low_bytes_o),
    .byte_eight_o  (byte_eight_o),
    .sign_byte_o   (sign_byte_o),
    .invalid_o     (invalid_o)
  );

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  function automatic bcd_image_t pack_bcd_image(operand_t op);
    bcd_image_t                 img;
    logic [63:0]                int_part;
    logic [fpbcd_pkg::BcdW-1:0] digits;
    img = Indef;
    digits = '0;
    if (op.is_zero) begin
      img = op.sign ? ZeroNeg : ZeroPos;
    end else if (op.is_nan || op.is_inf) begin
      img = Indef;
    end else if (op.is_subnorm) begin
      // sign is dropped for denormals
      img = ZeroPos;
    end else if (op.exponent <= fpbcd_pkg::ExpEdge) begin
      int_part = op.mantissa >> (63 - op.exponent);
      if (int_part < 64'(fpbcd_pkg::BcdLimit)) begin
        for (int i = 0; i < fpbcd_pkg::NumDigits; i++) begin
          digits[4*i +: 4] = 4'(int_part % 64'd10);
          int_part = int_part / 64'd10;
        end
        img = '{digits[63:0], digits[71:64],
                op.sign ? fpbcd_pkg::NegByte : fpbcd_pkg::PosByte, 1'b0};
      end
    end
    return img;
  endfunction

  function automatic operand_t mk_op(logic s, logic [15:0] e, logic [63:0] m,
                                     logic [3:0] cls);
    operand_t op;
    op.sign = s;
    op.exponent = e;
    op.mantissa = m;
    {op.is_zero, op.is_nan, op.is_inf, op.is_subnorm} = cls;
    return op;
  endfunction

  task automatic add_row(input operand_t op, input bit typed, input bcd_image_t img);
    stim_row_t row;
    row.op = op;
    row.typed = typed;
    row.img = img;
    directed_rows.push_back(row);
  endtask

  function automatic operand_t random_operand();
    operand_t    op;
    int unsigned sel;
    sel = $urandom_range(99);
    op = '0;
    op.sign = 1'($urandom_range(1));
    op.mantissa = {$urandom, $urandom};
    if (sel < 60) begin
      // mostly normalized, in range
      op.mantissa[63] = ($urandom_range(9) != 0);
      op.exponent = 16'($urandom_range(59));
    end else if (sel < 72) begin
      // hugging the 18-digit limit
      op.exponent = fpbcd_pkg::ExpEdge;
      op.mantissa = ((64'd999999999999999996 + 64'($urandom_range(7))) << 4)
                    | 64'($urandom_range(15));
    end else if (sel < 84) begin
      op.exponent = 16'($urandom);
    end else begin
      op.exponent = 16'($urandom);
      {op.is_zero, op.is_nan, op.is_inf, op.is_subnorm} = 4'($urandom_range(1, 15));
    end
    return op;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t: %s", $time, what);
    n_mismatch++;
  endtask

  // one transfer per call, with random idle cycles ahead of it
  task automatic send_operand(input operand_t op, input bcd_image_t img);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sign_i        <= op.sign;
    exponent_i    <= op.exponent;
    mantissa_i    <= op.mantissa;
    is_zero_i     <= op.is_zero;
    is_nan_i      <= op.is_nan;
    is_inf_i      <= op.is_inf;
    is_subnorm_i  <= op.is_subnorm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_images.push_back(img);
  endtask

  always @(posedge clk_i) begin
    bcd_image_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_images.size() == 0) begin
        flag_mismatch($sformatf("unexpected result low=%h", low_bytes_o));
      end else begin
        want = pending_images.pop_front();
        if (low_bytes_o !== want.low_bytes)
          flag_mismatch($sformatf("low_bytes %h, want %h", low_bytes_o, want.low_bytes));
        if (byte_eight_o !== want.byte_eight)
          flag_mismatch($sformatf("byte_eight %h, want %h", byte_eight_o, want.byte_eight));
        if (sign_byte_o !== want.sign_byte)
          flag_mismatch($sformatf("sign_byte %h, want %h", sign_byte_o, want.sign_byte));
        if (invalid_o !== want.invalid)
          flag_mismatch($sformatf("invalid %b, want %b", invalid_o, want.invalid));
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // ends the run if neither side moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    operand_t op;
    add_row(mk_op(1'b0, 16'd0, 64'd0, 4'b1000), 1'b1, ZeroPos);
    add_row(mk_op(1'b1, 16'hffff, '1, 4'b1000), 1'b1, ZeroNeg);
    // zero wins over every other class flag
    add_row(mk_op(1'b1, 16'hffff, '1, 4'b1111), 1'b1, ZeroNeg);
    add_row(mk_op(1'b0, 16'd3, 64'h8000000000000000, 4'b0100), 1'b1, Indef);
    add_row(mk_op(1'b1, 16'hffff, '1, 4'b0010), 1'b1, Indef);
    add_row(mk_op(1'b0, 16'd5, 64'h8000000000000001, 4'b0101), 1'b1, Indef);
    add_row(mk_op(1'b1, 16'd0, 64'd1, 4'b0001), 1'b1, ZeroPos);
    add_row(mk_op(1'b1, 16'hffff, '1, 4'b0001), 1'b1, ZeroPos);
    add_row(mk_op(1'b0, 16'd0, 64'h8000000000000000, 4'b0000), 1'b1,
            '{64'd1, 8'd0, fpbcd_pkg::PosByte, 1'b0});
    add_row(mk_op(1'b1, 16'd0, 64'd0, 4'b0000), 1'b1, ZeroNeg);
    add_row(mk_op(1'b1, 16'd0, 64'h7fffffffffffffff, 4'b0000), 1'b1, ZeroNeg);
    add_row(mk_op(1'b0, 16'd1, 64'hc000000000000000, 4'b0000), 1'b1,
            '{64'd3, 8'd0, fpbcd_pkg::PosByte, 1'b0});
    // largest 18-digit value, fraction nibble dropped
    add_row(mk_op(1'b0, 16'd59, 64'd15999999999999999999, 4'b0000), 1'b1,
            '{64'h9999999999999999, 8'h99, fpbcd_pkg::PosByte, 1'b0});
    add_row(mk_op(1'b1, 16'd59, 64'd15999999999999999999, 4'b0000), 1'b1,
            '{64'h9999999999999999, 8'h99, fpbcd_pkg::NegByte, 1'b0});
    add_row(mk_op(1'b0, 16'd59, 64'd16000000000000000000, 4'b0000), 1'b1, Indef);
    add_row(mk_op(1'b1, 16'd59, '1, 4'b0000), 1'b1, Indef);
    add_row(mk_op(1'b0, 16'd60, 64'h8000000000000000, 4'b0000), 1'b1, Indef);
    add_row(mk_op(1'b0, 16'd63, 64'h8000000000000000, 4'b0000), 1'b1, Indef);
    add_row(mk_op(1'b1, 16'hffff, '1, 4'b0000), 1'b1, Indef);
    add_row(mk_op(1'b0, 16'h8000, 64'd0, 4'b0000), 1'b1, Indef);
    add_row(mk_op(1'b0, 16'd58, '1, 4'b0000), 1'b0, '0);
    add_row(mk_op(1'b1, 16'd31, 64'hdeadbeefcafef00d, 4'b0000), 1'b0, '0);
    add_row(mk_op(1'b0, 16'd52, 64'hfedcba9876543210, 4'b0000), 1'b0, '0);
    add_row(mk_op(1'b1, 16'd59, 64'd0, 4'b0000), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_operand(directed_rows[i].op,
                   directed_rows[i].typed ? directed_rows[i].img
                                          : pack_bcd_image(directed_rows[i].op));
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      repeat (ItemsPerPhase) begin
        op = random_operand();
        send_operand(op, pack_bcd_image(op));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_images.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
